// ----- src/esof_pkg.sv -----
package esof_pkg;

    // Field widths
    localparam int COUNT_W = 16;
    localparam int SPEED_W = 32;
    localparam int TOTAL_W = 32;
    localparam int INNOV_W = SPEED_W + 1;
    localparam int PROD_W  = INNOV_W + 17;
    localparam int BAND_W  = 23;

    // Configuration register indexes
    localparam logic [1:0] REG_ALPHA     = 2'd0;
    localparam logic [1:0] REG_INV_LEFT  = 2'd1;
    localparam logic [1:0] REG_INV_RIGHT = 2'd2;

    // Register reset values
    localparam logic [15:0] ALPHA_RESET     = 16'd19661;
    localparam logic        INV_LEFT_RESET  = 1'b1;
    localparam logic        INV_RIGHT_RESET = 1'b0;

    // Filter constants in Q0.16 or Q16.16
    localparam logic [15:0] ALPHA_MIN     = 16'd3277;
    localparam logic [15:0] ALPHA_MAX     = 16'd62259;
    localparam logic [13:0] OUTLIER_SCALE = 14'd9830;
    localparam logic [14:0] BAND_SLOPE    = 15'd19661;
    localparam logic [BAND_W-1:0] BAND_BASE = BAND_W'(4 * 65536);
    localparam logic [BAND_W-1:0] BAND_CAP  = BAND_W'(25 * 65536);

    // Filter coefficients shared by both lanes
    typedef struct packed {
        logic [15:0] coef;
        logic [15:0] coef_gated;
    } coef_t;

    // Per-item control of one lane
    typedef struct packed {
        logic step;
        logic clear;
        logic first;
        logic invert;
    } lane_ctrl_t;

    // Values one lane reports for an item
    typedef struct packed {
        logic [15:0]        outliers;
        logic [TOTAL_W-1:0] total;
        logic [15:0]        delta;
        logic [15:0]        speed;
    } lane_result_t;

    // Clamp the written coefficient to the 0.05..0.95 band.
    function automatic logic [15:0] clamp_alpha(input logic [15:0] a);
        logic [15:0] r;
        r = a;
        if (a < ALPHA_MIN) begin
            r = ALPHA_MIN;
        end else if (a > ALPHA_MAX) begin
            r = ALPHA_MAX;
        end
        return r;
    endfunction

    // Coefficient used on an outlier: 0.15 of the clamped one, rounded down.
    function automatic logic [15:0] gate_alpha(input logic [15:0] a);
        logic [29:0] p;
        p = 30'(a) * 30'(OUTLIER_SCALE);
        return {2'b00, p[29:16]};
    endfunction

endpackage

// ----- src/encoder_speed_outlier_filter_unit.sv -----
// Two-wheel encoder speed filter.
// The s_ channel carries one tick: both raw 16-bit counter readings and a clear
// flag. For each tick the block returns one transfer on the m_ channel with the
// filtered speed, corrected delta, odometry total and outlier count of each wheel.
// The two wheels run in separate lanes that update their state in the accept
// cycle; each lane forms both candidate coefficient products in parallel and the
// band test picks one.
// Results are registered in the output buffer and are driven onto m_tdata from it.
// Throughput is one tick per cycle while the receiver keeps m_tready high.
// A two-entry output buffer holds results when the receiver stalls; s_tready
// falls once both entries are full and rises as soon as one drains.
// The cfg channel writes coefficient and direction registers; it is always ready
// and should only be used while the block has no results outstanding.
// After reset (aresetn low, synchronous) all wheel state is zero, the first tick
// reports a zero delta, and the registers hold their reset values.
module encoder_speed_outlier_filter_unit
    import esof_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Input ticks
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // left_count[15:0], right_count[31:16]
    input  logic         s_tuser,   // clear_filters[0]
    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // left_speed, left_delta, left_total, left_outliers,
                                    // right_speed, right_delta, right_total,
                                    // right_outliers
    // Register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [15:0]  coef_reg, coef_next;
    logic [15:0]  coef_gated_reg, coef_gated_next;
    logic         inv_left_reg, inv_left_next;
    logic         inv_right_reg, inv_right_next;
    logic         first_reg, first_next;

    logic         accept;
    logic         cfg_write;
    coef_t        coefs;
    lane_ctrl_t   ctrl_left;
    lane_ctrl_t   ctrl_right;
    lane_result_t res_left;
    lane_result_t res_right;
    logic [159:0] result_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;

    // Register decode; the coefficient is clamped and scaled when written.
    always_comb begin
        coef_next       = coef_reg;
        coef_gated_next = coef_gated_reg;
        inv_left_next   = inv_left_reg;
        inv_right_next  = inv_right_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_ALPHA: begin
                    coef_next       = clamp_alpha(cfg_data);
                    coef_gated_next = gate_alpha(clamp_alpha(cfg_data));
                end
                REG_INV_LEFT: begin
                    inv_left_next = cfg_data[0];
                end
                REG_INV_RIGHT: begin
                    inv_right_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // First-tick flag stays set across clear ticks.
    always_comb begin
        first_next = first_reg;
        if (accept && !s_tuser) begin
            first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg       <= clamp_alpha(ALPHA_RESET);
            coef_gated_reg <= gate_alpha(clamp_alpha(ALPHA_RESET));
            inv_left_reg   <= INV_LEFT_RESET;
            inv_right_reg  <= INV_RIGHT_RESET;
            first_reg      <= 1'b1;
        end else begin
            coef_reg       <= coef_next;
            coef_gated_reg <= coef_gated_next;
            inv_left_reg   <= inv_left_next;
            inv_right_reg  <= inv_right_next;
            first_reg      <= first_next;
        end
    end

    assign coefs.coef       = coef_reg;
    assign coefs.coef_gated = coef_gated_reg;

    assign ctrl_left.step    = accept;
    assign ctrl_left.clear   = s_tuser;
    assign ctrl_left.first   = first_reg;
    assign ctrl_left.invert  = inv_left_reg;
    assign ctrl_right.step   = accept;
    assign ctrl_right.clear  = s_tuser;
    assign ctrl_right.first  = first_reg;
    assign ctrl_right.invert = inv_right_reg;

    esof_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl_left),
        .count   (s_tdata[15:0]),
        .coefs   (coefs),
        .result  (res_left)
    );

    esof_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl_right),
        .count   (s_tdata[31:16]),
        .coefs   (coefs),
        .result  (res_right)
    );

    // Merge both lanes into one result word, left wheel in the low half.
    assign result_data = {res_right.outliers, res_right.total, res_right.delta,
                          res_right.speed, res_left.outliers, res_left.total,
                          res_left.delta, res_left.speed};

    esof_out_buf #(
        .WIDTH (160)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- src/esof_lane.sv -----
module esof_lane
    import esof_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctrl_t         ctrl,
    input  logic [COUNT_W-1:0] count,
    input  coef_t              coefs,
    output lane_result_t       result
);

    logic [COUNT_W-1:0]        prev_count_reg, prev_count_next;
    logic [TOTAL_W-1:0]        total_reg, total_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic [15:0]               delta_reg, delta_next;
    logic [15:0]               outliers_reg, outliers_next;

    logic [15:0]               delta_raw;
    logic [15:0]               delta_corr;
    logic signed [INNOV_W-1:0] innov;
    logic [INNOV_W-1:0]        innov_mag;
    logic [SPEED_W-1:0]        speed_mag;
    logic [37:0]               band_prod;
    logic [BAND_W-1:0]         band_sum;
    logic [BAND_W-1:0]         band;
    logic                      outlier;
    logic signed [PROD_W-1:0]  prod_norm;
    logic signed [PROD_W-1:0]  prod_gated;
    logic signed [PROD_W-1:0]  prod_sel;
    logic [15:0]               speed_int;

    // Wrapped difference to the previous reading, zero on the first tick.
    always_comb begin
        delta_raw = count - prev_count_reg;
        if (ctrl.first) begin
            delta_raw = '0;
        end
        delta_corr = ctrl.invert ? 16'(-delta_raw) : delta_raw;
    end

    // Innovation against the current estimate, in Q16.16.
    always_comb begin
        innov     = $signed({delta_corr[15], delta_corr, 16'h0000})
                  - $signed({speed_reg[SPEED_W-1], speed_reg});
        innov_mag = innov[INNOV_W-1] ? INNOV_W'(-innov) : INNOV_W'(innov);
        speed_mag = speed_reg[SPEED_W-1] ? SPEED_W'(-speed_reg) : SPEED_W'(speed_reg);
    end

    // Credible band: 4 + 0.3 * |speed|, capped at 25. Large speeds reach the cap.
    always_comb begin
        band_prod = 38'(speed_mag[22:0]) * 38'(BAND_SLOPE);
        band_sum  = BAND_BASE + BAND_W'(band_prod[37:16]);
        if (speed_mag[SPEED_W-1:23] != '0 || band_sum > BAND_CAP) begin
            band = BAND_CAP;
        end else begin
            band = band_sum;
        end
        outlier = innov_mag > INNOV_W'(band);
    end

    // Both candidate updates run in parallel; the band test picks one.
    always_comb begin
        prod_norm  = $signed({1'b0, coefs.coef}) * innov;
        prod_gated = $signed({1'b0, coefs.coef_gated}) * innov;
        prod_sel   = outlier ? prod_gated : prod_norm;
    end

    // Next lane state.
    always_comb begin
        prev_count_next = prev_count_reg;
        total_next      = total_reg;
        speed_next      = speed_reg;
        delta_next      = delta_reg;
        outliers_next   = outliers_reg;
        if (ctrl.clear) begin
            speed_next    = '0;
            delta_next    = '0;
            outliers_next = '0;
        end else begin
            prev_count_next = count;
            delta_next      = delta_corr;
            total_next      = total_reg + TOTAL_W'($signed(delta_corr));
            speed_next      = speed_reg + $signed(prod_sel[SPEED_W+15:16]);
            if (outlier) begin
                outliers_next = outliers_reg + 16'd1;
            end
        end
    end

    // Speed truncated toward zero to whole pulses per tick.
    always_comb begin
        speed_int = speed_next[SPEED_W-1:16];
        if (speed_next[SPEED_W-1] && speed_next[15:0] != '0) begin
            speed_int = speed_int + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg <= '0;
            total_reg      <= '0;
            speed_reg      <= '0;
            delta_reg      <= '0;
            outliers_reg   <= '0;
        end else if (ctrl.step) begin
            prev_count_reg <= prev_count_next;
            total_reg      <= total_next;
            speed_reg      <= speed_next;
            delta_reg      <= delta_next;
            outliers_reg   <= outliers_next;
        end
    end

    assign result.speed    = speed_int;
    assign result.delta    = delta_next;
    assign result.total    = total_next;
    assign result.outliers = outliers_next;

endmodule

// ----- src/esof_out_buf.sv -----
module esof_out_buf
    import esof_pkg::*;
#(
    parameter int WIDTH = 160
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             head_valid_reg, head_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] head_reg, head_next;
    logic [WIDTH-1:0] skid_reg, skid_next;
    logic             push;
    logic             pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = head_valid_reg && out_ready;

    // Two-entry buffer: the skid entry catches a transfer while the head stalls.
    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else if (push) begin
                head_next       = in_data;
                head_valid_next = 1'b1;
            end else begin
                head_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

// ----- bench/tb_encoder_speed_outlier_filter_unit.sv -----
module tb_encoder_speed_outlier_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import esof_pkg::*;

    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     LONG_HOLD      = 80;
    localparam longint LO_ALPHA       = 3277;
    localparam longint HI_ALPHA       = 62259;
    localparam longint GATE_SCALE     = 9830;
    localparam longint BAND_GAIN      = 19661;
    localparam longint BAND_FLOOR     = 4 * 65536;
    localparam longint BAND_CEIL      = 25 * 65536;

    // One tick as offered on the input channel.
    typedef struct {
        logic [15:0] left_count;
        logic [15:0] right_count;
        logic        clear;
    } tick_t;

    // Result layout, highest field first, matching m_tdata.
    typedef struct packed {
        logic [15:0] outliers;
        logic [31:0] total;
        logic [15:0] delta;
        logic [15:0] speed;
    } wheel_report_t;

    typedef struct packed {
        wheel_report_t [1:0] wheel;
    } tick_report_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [159:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data  = '0;

    // Register copies and wheel state of the predictor.
    logic [15:0] alpha_q16_reg     = 16'd19661;
    logic        invert_left_reg   = 1'b1;
    logic        invert_right_reg  = 1'b0;
    logic [15:0] prev_count [2]    = '{default: '0};
    logic        first_tick_pending = 1'b1;
    logic [31:0] odometry [2]      = '{default: '0};
    longint      speed_fx [2]      = '{default: 0};
    logic [15:0] last_delta [2]    = '{default: '0};
    logic [15:0] outlier_count [2] = '{default: '0};

    tick_t        tick_q [$];
    tick_report_t expected_reports [$];

    int ticks_queued   = 0;
    int ticks_offered  = 0;
    int ticks_taken    = 0;
    int reports_taken  = 0;
    int fail_count     = 0;
    int clears_seen    = 0;
    int outlier_events = 0;
    int settings_used  = 0;
    int tx_idle_max    = 0;
    int rx_idle_max    = 0;
    int tx_gap         = 0;
    int rx_stall       = 0;
    int rx_hold_req    = 0;
    int rx_hold_done   = 0;
    int rx_reports_seen = 0;
    int quiet_cycles   = 0;
    logic [15:0] wheel_pos [2]  = '{default: '0};
    int          wheel_rate [2] = '{default: 0};

    encoder_speed_outlier_filter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Speed in whole pulses per tick: truncate toward zero, then saturate.
    function automatic logic [15:0] speed_to_pulses(input longint s);
        longint v;
        v = (s >= 0) ? (s >>> 16) : -((-s) >>> 16);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Advance one wheel by one tick: clear, or delta, odometry and gated low-pass update.
    function automatic void advance_wheel(input int w, input logic [15:0] cnt,
                                          input logic inv, input logic clr,
                                          input logic first);
        logic [15:0] d;
        longint      dv, sp, innov, mag, band, coef;
        if (clr) begin
            speed_fx[w]      = 0;
            last_delta[w]    = '0;
            outlier_count[w] = '0;
            return;
        end
        d = cnt - prev_count[w];
        prev_count[w] = cnt;
        if (first) d = '0;
        // Negating the most negative delta wraps back onto itself.
        if (inv) d = 16'(-d);
        last_delta[w] = d;
        dv = longint'($signed(d));
        odometry[w] = odometry[w] + dv[31:0];

        coef = longint'(alpha_q16_reg);
        if (coef < LO_ALPHA) coef = LO_ALPHA;
        if (coef > HI_ALPHA) coef = HI_ALPHA;

        sp    = speed_fx[w];
        innov = dv * 65536 - sp;
        mag   = (sp < 0) ? -sp : sp;
        band  = BAND_FLOOR + ((mag * BAND_GAIN) >>> 16);
        if (band > BAND_CEIL) band = BAND_CEIL;
        if (innov > band || innov < -band) begin
            coef = (coef * GATE_SCALE) >>> 16;
            outlier_count[w] = outlier_count[w] + 16'd1;
            outlier_events++;
        end
        speed_fx[w] = sp + ((coef * innov) >>> 16);
    endfunction

    function automatic tick_report_t predict_report(input tick_t t);
        tick_report_t r;
        logic         first;
        first = first_tick_pending;
        advance_wheel(0, t.left_count, invert_left_reg, t.clear, first);
        advance_wheel(1, t.right_count, invert_right_reg, t.clear, first);
        // A clear tick leaves the pending first reading in place.
        if (!t.clear) first_tick_pending = 1'b0;
        else clears_seen++;
        for (int w = 0; w < 2; w++) begin
            r.wheel[w].speed    = speed_to_pulses(speed_fx[w]);
            r.wheel[w].delta    = last_delta[w];
            r.wheel[w].total    = odometry[w];
            r.wheel[w].outliers = outlier_count[w];
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_report(input tick_report_t want, input tick_report_t got);
        string side;
        for (int w = 0; w < 2; w++) begin
            side = (w == 0) ? "left" : "right";
            check_field({side, "_speed"}, $signed(want.wheel[w].speed),
                        $signed(got.wheel[w].speed));
            check_field({side, "_delta"}, $signed(want.wheel[w].delta),
                        $signed(got.wheel[w].delta));
            check_field({side, "_total"}, $signed(want.wheel[w].total),
                        $signed(got.wheel[w].total));
            check_field({side, "_outliers"}, want.wheel[w].outliers,
                        got.wheel[w].outliers);
        end
    endfunction

    // Input driver: presents queued ticks, with a random gap after each transfer.
    always @(negedge aclk) begin : drive_ticks
        logic  next_valid;
        tick_t t;
        next_valid = s_tvalid;
        if (s_tvalid && ticks_taken == ticks_offered) next_valid = 1'b0;
        if (aresetn && !next_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (tick_q.size() > 0) begin
                t = tick_q.pop_front();
                s_tdata <= {t.right_count, t.left_count};
                s_tuser <= t.clear;
                next_valid = 1'b1;
                ticks_offered++;
                tx_gap = $urandom_range(0, tx_idle_max);
            end
        end
        s_tvalid <= next_valid;
    end

    // Result receiver: random stall after each transfer, or a long hold on request.
    always @(negedge aclk) begin : drive_ready
        if (rx_hold_done != rx_hold_req) begin
            rx_hold_done = rx_hold_req;
            rx_stall = LONG_HOLD;
        end else if (rx_reports_seen != reports_taken) begin
            rx_reports_seen = reports_taken;
            rx_stall = $urandom_range(0, rx_idle_max);
        end
        if (aresetn && rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    // Monitor: tracks register writes, predicts accepted ticks, checks results.
    always @(posedge aclk) begin : watch_ports
        tick_t        t;
        tick_report_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ALPHA:     alpha_q16_reg = cfg_data;
                    REG_INV_LEFT:  invert_left_reg = cfg_data[0];
                    REG_INV_RIGHT: invert_right_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result transfer with no tick outstanding, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_report(want, tick_report_t'(m_tdata));
                end
                reports_taken++;
            end
            if (s_tvalid && s_tready) begin
                t.left_count  = s_tdata[15:0];
                t.right_count = s_tdata[31:16];
                t.clear       = s_tuser;
                expected_reports.push_back(predict_report(t));
                ticks_taken++;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic void push_tick(input logic [15:0] left, input logic [15:0] right,
                                      input logic clr);
        tick_t t;
        t.left_count  = left;
        t.right_count = right;
        t.clear       = clr;
        tick_q.push_back(t);
        ticks_queued++;
    endfunction

    // Sender pause: wait until every queued tick has been taken and answered.
    task automatic wait_drained();
        while (ticks_taken != ticks_queued || expected_reports.size() != 0) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One setting of the registers followed by random wheel motion.
    task automatic run_phase(input logic [15:0] alpha, input logic inv_l, input logic inv_r,
                             input int tx_max, input int rx_max, input int rate_span,
                             input bit long_hold, input int n);
        logic [15:0] cnt [2];
        int          r;
        int          glitch;
        write_register(REG_ALPHA, alpha);
        write_register(REG_INV_LEFT, {15'd0, inv_l});
        write_register(REG_INV_RIGHT, {15'd0, inv_r});
        settings_used++;
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        if (long_hold) rx_hold_req++;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                push_tick(16'($urandom), 16'($urandom), 1'b1);
            end else if (r < 8) begin
                // Counter noise: readings unrelated to the wheel motion.
                push_tick(16'($urandom), 16'($urandom), 1'b0);
            end else begin
                for (int w = 0; w < 2; w++) begin
                    if ($urandom_range(0, 49) == 0) begin
                        wheel_rate[w] = int'($urandom_range(0, 2 * rate_span)) - rate_span;
                    end else begin
                        wheel_rate[w] += int'($urandom_range(0, 4)) - 2;
                    end
                    glitch = 0;
                    if ($urandom_range(0, 19) == 0) begin
                        glitch = int'($urandom_range(0, 400)) - 200;
                    end
                    wheel_pos[w] = wheel_pos[w] + 16'(wheel_rate[w]);
                    cnt[w] = wheel_pos[w] + 16'(glitch);
                end
                push_tick(cnt[0], cnt[1], 1'b0);
            end
        end
        wait_drained();
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed ticks under the reset register values.
        tx_idle_max = 2;
        rx_idle_max = 2;
        push_tick(16'hAAAA, 16'h5555, 1'b1);  // clear while the first reading is pending
        push_tick(16'h8001, 16'h7FFE, 1'b0);  // first reading gives zero deltas
        push_tick(16'h8004, 16'h8001, 1'b0);
        push_tick(16'h8007, 16'h8004, 1'b0);
        push_tick(16'h800A, 16'h8007, 1'b0);
        push_tick(16'h0000, 16'hFFFF, 1'b0);  // large positive jumps, negated on the left
        push_tick(16'h7FFF, 16'h7FFE, 1'b0);  // largest positive delta
        push_tick(16'hFFFF, 16'hFFFE, 1'b0);  // most negative delta, negated on the left
        push_tick(16'hFFFF, 16'hFFFE, 1'b0);
        push_tick(16'h1234, 16'h5678, 1'b1);  // clear ignores the readings
        push_tick(16'h0002, 16'h0001, 1'b0);  // delta across the counter wrap
        push_tick(16'h0002, 16'h0001, 1'b1);
        push_tick(16'h0007, 16'h0006, 1'b0);
        push_tick(16'h000C, 16'h000B, 1'b0);
        push_tick(16'h0011, 16'h0010, 1'b0);
        push_tick(16'h0016, 16'h0015, 1'b0);
        push_tick(16'h0516, 16'h0015, 1'b0);  // single-tick spike on the left
        push_tick(16'h001B, 16'h001A, 1'b0);
        push_tick(16'h0020, 16'h001F, 1'b0);
        wait_drained();

        // Random motion across register settings and handshake pressure.
        run_phase(16'd0,     1'b0, 1'b1, 0,  0,  40,    1'b0, 240);
        run_phase(16'hFFFF,  1'b1, 1'b1, 16, 16, 300,   1'b0, 240);
        run_phase(16'd3277,  1'b0, 1'b0, 0,  3,  40,    1'b1, 240);
        run_phase(16'd62259, 1'b1, 1'b0, 0,  16, 32767, 1'b0, 240);
        run_phase(16'd3276,  1'b0, 1'b1, 16, 0,  8,     1'b0, 240);
        run_phase(16'd62260, 1'b1, 1'b1, 8,  8,  2000,  1'b0, 240);
        run_phase(16'($urandom), 1'($urandom), 1'($urandom), 16, 16, 300, 1'b0, 240);
        run_phase(16'd19661, 1'b1, 1'b0, 4,  12, 100,   1'b0, 220);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_reports.size());
            fail_count += expected_reports.size();
        end
        $display("Covered %0d ticks (%0d clears, %0d outlier updates) over %0d settings.",
                 ticks_taken, clears_seen, outlier_events, settings_used);
        $display("Stalls on both sides, a long receiver hold, %0d results compared.",
                 reports_taken);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/esof_pkg.sv
src/esof_lane.sv
src/esof_out_buf.sv
src/encoder_speed_outlier_filter_unit.sv
bench/tb_encoder_speed_outlier_filter_unit.sv
